[hdl/ffba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and default sizes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Default sizes
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int ALIGN_BYTES_DEF  = 8;
  localparam int HEADER_BYTES_DEF = 12;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_LIMIT = CFG_INDEX_W'(1);

  // Commands
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_ZERO_SIZE    = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN_ADDR = 2'd3;

  // Request word
  typedef struct packed {
    logic        command;
    logic [31:0] request_size;
    logic [31:0] release_address;
  } req_t;

  // Result word
  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } rsp_t;

  // Block table entry: payload address is kept instead of header address
  typedef struct packed {
    logic        free;
    logic [31:0] bytes;
    logic [31:0] payload;
  } entry_t;

endpackage
`default_nettype wire

[hdl/ffba_align.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_align
// Rounds a request size up to a multiple of ALIGN_BYTES. The quotient comes
// from a multiply by the alignment's reciprocal and the remainder from one
// subtract. done follows the product and remainder stages, with want rounded.
// ----------------------------------------------------------------------------
module ffba_align #(
  parameter int ALIGN_BYTES = ffba_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [31:0] size,
  output logic             done,
  output logic [32:0]      want
);
  import ffba_pkg::*;

  localparam int R_W   = $clog2(ALIGN_BYTES + 1);
  localparam int SHIFT = 32 + $clog2(ALIGN_BYTES);
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
  localparam logic [32:0] RECIP = 33'(RECIP_64);
  localparam logic [31:0] A_32  = 32'(ALIGN_BYTES);
  localparam logic [32:0] A_33  = 33'(ALIGN_BYTES);

  logic           prod_valid;
  logic           rem_valid;
  logic [31:0]    size_q;
  logic [64:0]    prod;
  logic [31:0]    quot;
  logic [R_W-1:0] rem;

  // Take the quotient from the top of the reciprocal product
  assign quot = 32'(prod >> SHIFT);

  // Advance the stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      rem_valid  <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= go;
      rem_valid  <= prod_valid;
      done       <= rem_valid;
    end
  end

  // Datapath: multiply, then remainder, then the rounded size
  always_ff @(posedge clk) begin
    if (go) begin
      size_q <= size;
      prod   <= 65'(size) * 65'(RECIP);
    end
    if (prod_valid) begin
      rem <= R_W'(size_q - quot * A_32);
    end
    if (rem_valid) begin
      if (rem == '0) begin
        want <= {1'b0, size_q};
      end else begin
        want <= {1'b0, size_q} + (A_33 - 33'(rem));
      end
    end
  end

endmodule
`default_nettype wire

[hdl/first_fit_block_allocator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a block table held in one synchronous memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// result for one cycle with done high and must be taken then. A release of
// address 0 and an allocate of size 0 answer in the cycle after start. A
// release or an allocate reads N table entries before the matching entry
// (at most the number of blocks created, up to MAX_BLOCKS). The table scan
// reads one entry per cycle from the single memory port; an allocate first
// passes the ALIGN and NEED states, rounding the size in the alignment unit
// and settling the growth sums. busy drops in the cycle the result is shown.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int ALIGN_BYTES  = ffba_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire ffba_pkg::req_t                request,
  output logic                               done,
  output ffba_pkg::rsp_t                     result,
  input  wire logic                          cfg_write,
  input  wire logic [ffba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import ffba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_BLOCKS);
  localparam int HDR_RND = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam logic [33:0] HDR_RND_34 = 34'(HDR_RND);
  localparam logic [33:0] HEADER_34  = 34'(HEADER_BYTES);
  localparam logic [31:0] HEADER_32  = 32'(HEADER_BYTES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALIGN = 2'd1;
  localparam logic [1:0] S_NEED  = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  // Configuration registers
  logic [31:0] heap_base;
  logic [31:0] heap_limit;

  // Control
  logic [1:0]       state;
  logic             cmd;
  logic [31:0]      rel_addr;
  logic [CNT_W-1:0] issue_idx;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] block_count;
  logic [31:0]      grown_bytes;

  // Growth pipeline
  logic [32:0] old_brk;
  logic [33:0] need;
  logic        grow_fail;
  logic [31:0] new_bytes;
  logic [31:0] new_payload;
  logic [31:0] new_grown;
  logic [34:0] new_brk_sum;
  logic [34:0] grown_sum;

  // Table memory
  entry_t           mem [MAX_BLOCKS];
  entry_t           rd_data;
  logic             rd_en;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Alignment unit
  logic        align_go;
  logic        align_done;
  logic [32:0] want;

  logic accept;
  logic hit;
  logic issue_more;
  logic full;

  ffba_align #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_align (
    .clk (clk),
    .rst (rst),
    .go  (align_go),
    .size(request.request_size),
    .done(align_done),
    .want(want)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign align_go   = accept && (request.command == CMD_ALLOC) && (request.request_size != '0);
  assign issue_more = (issue_idx != block_count);
  assign full       = (block_count == FULL_COUNT);

  // Match the word read in the previous cycle
  always_comb begin
    hit = 1'b0;
    if (rd_pend) begin
      if (cmd == CMD_ALLOC) begin
        hit = rd_data.free && ({1'b0, rd_data.bytes} >= want);
      end else begin
        hit = (rd_data.payload == rel_addr);
      end
    end
  end

  assign rd_en = (state == S_SCAN) && !hit && issue_more;

  // Write back on a hit, append on a successful grow
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = rd_data;
    if (state == S_SCAN) begin
      if (hit) begin
        mem_we         = 1'b1;
        mem_wdata.free = (cmd == CMD_RELEASE);
      end else if (!issue_more && !rd_pend && (cmd == CMD_ALLOC) && !full && !grow_fail) begin
        mem_we            = 1'b1;
        mem_waddr         = block_count[IDX_W-1:0];
        mem_wdata.free    = 1'b0;
        mem_wdata.bytes   = new_bytes;
        mem_wdata.payload = new_payload;
      end
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[issue_idx[IDX_W-1:0]];
      rd_idx  <= issue_idx[IDX_W-1:0];
    end
  end

  // Configuration writes; other indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEAP_BASE:  heap_base  <= cfg_data;
        REG_HEAP_LIMIT: heap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Growth arithmetic, free running; settles once the size is rounded, before the scan
  assign new_brk_sum = 35'(old_brk) + 35'(need);
  assign grown_sum   = 35'(grown_bytes) + 35'(need);

  always_ff @(posedge clk) begin
    old_brk     <= 33'(heap_base) + 33'(grown_bytes);
    need        <= 34'(want) + HDR_RND_34;
    grow_fail   <= (new_brk_sum > 35'(heap_limit)) || (grown_sum[34:32] != 3'b0);
    new_bytes   <= 32'(need - HEADER_34);
    new_payload <= old_brk[31:0] + HEADER_32;
    new_grown   <= grown_sum[31:0];
  end

  // Request sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      rd_pend     <= 1'b0;
      issue_idx   <= '0;
      block_count <= '0;
      grown_bytes <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd       <= request.command;
            rel_addr  <= request.release_address;
            issue_idx <= '0;
            rd_pend   <= 1'b0;
            if (request.command == CMD_ALLOC) begin
              if (request.request_size == '0) begin
                done                 <= 1'b1;
                result.block_address <= '0;
                result.status        <= ST_ZERO_SIZE;
              end else begin
                state <= S_ALIGN;
              end
            end else begin
              if (request.release_address == '0) begin
                done                 <= 1'b1;
                result.block_address <= '0;
                result.status        <= ST_OK;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_ALIGN: begin
          if (align_done) begin
            state <= S_NEED;
          end
        end
        S_NEED: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (hit) begin
            state                <= S_IDLE;
            done                 <= 1'b1;
            result.block_address <= (cmd == CMD_ALLOC) ? rd_data.payload : '0;
            result.status        <= ST_OK;
          end else if (!issue_more && !rd_pend) begin
            // Table exhausted without a match
            state <= S_IDLE;
            done  <= 1'b1;
            if (cmd == CMD_RELEASE) begin
              result.block_address <= '0;
              result.status        <= ST_UNKNOWN_ADDR;
            end else if (full || grow_fail) begin
              result.block_address <= '0;
              result.status        <= ST_NO_MEMORY;
            end else begin
              result.block_address <= new_payload;
              result.status        <= ST_OK;
              block_count          <= block_count + 1'b1;
              grown_bytes          <= new_grown;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
